@@ rtl/belpd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// belpd_pkg: shared types and constants of the long-press detector
// Field widths, request and result codes, and the item and result structs.
// ----------------------------------------------------------------------------
package belpd_pkg;

    // Reset button hold counter width
    localparam int HOLD_BITS = 20;

    // Configuration register widths and reset values
    localparam int TPS_W      = 10;
    localparam int LS_W       = 8;
    localparam int CFG_W      = 10;
    localparam int CFG_ADDR_W = 1;
    localparam int LIMIT_W    = LS_W + 1 + TPS_W;
    localparam int CMP_W      = (HOLD_BITS > LIMIT_W) ? HOLD_BITS : LIMIT_W;

    localparam logic [TPS_W-1:0]   TPS_RESET   = TPS_W'(100);
    localparam logic [LS_W-1:0]    LS_RESET    = LS_W'(5);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'((5 + 1) * 100);

    // Bit positions of the buttons in the level vectors
    localparam int B_POWER  = 0;
    localparam int B_SELECT = 1;
    localparam int B_RESET  = 2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TPS = 1'd0,
        CFG_LS  = 1'd1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_POLL   = 2'd1,
        OP_STATUS = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        SEL_POWER  = 2'd0,
        SEL_RESET  = 2'd1,
        SEL_SELECT = 2'd2
    } sel_t;

    typedef enum logic [1:0] {
        BTN_NONE   = 2'd0,
        BTN_POWER  = 2'd1,
        BTN_SELECT = 2'd2,
        BTN_RESET  = 2'd3
    } btn_t;

    typedef enum logic [1:0] {
        KIND_SHORT    = 2'd0,
        KIND_LONG     = 2'd1,
        KIND_PRESSED  = 2'd2,
        KIND_RELEASED = 2'd3
    } kind_t;

    typedef struct packed {
        op_t        op;
        logic       power_level;
        logic       select_level;
        logic       reset_level;
        logic [1:0] status_button;
    } item_t;

    typedef struct packed {
        btn_t  button_id;
        kind_t event_kind;
    } result_t;

    // True for requests that return a result item
    function automatic logic op_has_result(input op_t op);
        logic r;
        begin
            r = (op == OP_POLL) || (op == OP_STATUS);
            return r;
        end
    endfunction

endpackage
`default_nettype wire

@@ rtl/belpd_in_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// belpd_in_stage: input register
// Captures one item from the slave stream and holds it until it advances.
// ----------------------------------------------------------------------------
module belpd_in_stage
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,
    input  wire logic [1:0]           s_tuser,
    input  wire logic                 advance,
    output belpd_pkg::item_t          item,
    output logic                      item_valid
);

    logic             valid_reg;
    logic             valid_next;
    belpd_pkg::item_t item_reg;

    assign s_tready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tready)
        begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload: load on every accepted item
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.op            <= belpd_pkg::op_t'(s_tuser[1:0]);
            item_reg.power_level   <= s_tdata[0];
            item_reg.select_level  <= s_tdata[1];
            item_reg.reset_level   <= s_tdata[2];
            item_reg.status_button <= s_tdata[4:3];
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule
`default_nettype wire

@@ rtl/belpd_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// belpd_core: button state and request handling
// Edge detection, pending events, reset hold counter and request decode.
// ----------------------------------------------------------------------------
module belpd_core
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [belpd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [belpd_pkg::CFG_W-1:0]         cfg_wdata,
    input  wire belpd_pkg::item_t                    item,
    input  wire logic                                fire,
    output belpd_pkg::result_t                       result
);

    logic [belpd_pkg::TPS_W-1:0]     tps_reg;
    logic [belpd_pkg::LS_W-1:0]      ls_reg;
    logic [belpd_pkg::LIMIT_W-1:0]   limit_reg;
    logic [belpd_pkg::LIMIT_W-1:0]   limit_next;

    logic [2:0]                      last_reg,  last_next;
    logic [2:0]                      press_reg, press_next;
    logic [2:0]                      pend_reg,  pend_next;
    logic [belpd_pkg::HOLD_BITS-1:0] hold_reg,  hold_next;
    logic                            long_reg,  long_next;

    logic [2:0]                      lv;
    logic [2:0]                      falls;
    logic [2:0]                      rises;
    logic [2:0]                      pend_upd;
    logic                            long_upd;
    logic                            live_bit;

    // Threshold is recomputed on each register write, so it is current
    // at the same edge as the registers themselves.
    always_comb
    begin
        limit_next = limit_reg;
        if (cfg_we)
        begin
            case (belpd_pkg::cfg_idx_t'(cfg_addr))
                belpd_pkg::CFG_TPS:
                begin
                    limit_next = (belpd_pkg::LIMIT_W'(ls_reg) + belpd_pkg::LIMIT_W'(1))
                                 * belpd_pkg::LIMIT_W'(cfg_wdata[belpd_pkg::TPS_W-1:0]);
                end
                belpd_pkg::CFG_LS:
                begin
                    limit_next = (belpd_pkg::LIMIT_W'(cfg_wdata[belpd_pkg::LS_W-1:0])
                                  + belpd_pkg::LIMIT_W'(1))
                                 * belpd_pkg::LIMIT_W'(tps_reg);
                end
                default:
                begin
                    limit_next = limit_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg   <= belpd_pkg::TPS_RESET;
            ls_reg    <= belpd_pkg::LS_RESET;
            limit_reg <= belpd_pkg::LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
            if (cfg_we && (belpd_pkg::cfg_idx_t'(cfg_addr) == belpd_pkg::CFG_TPS))
            begin
                tps_reg <= cfg_wdata[belpd_pkg::TPS_W-1:0];
            end
            if (cfg_we && (belpd_pkg::cfg_idx_t'(cfg_addr) == belpd_pkg::CFG_LS))
            begin
                ls_reg <= cfg_wdata[belpd_pkg::LS_W-1:0];
            end
        end
    end

    // Button state update, then request decode on the updated state
    always_comb
    begin
        lv = {item.reset_level, item.select_level, item.power_level};
        falls = last_reg & ~lv;
        rises = ~last_reg & lv & press_reg;

        hold_next = hold_reg;
        if (falls[belpd_pkg::B_RESET])
        begin
            hold_next = '0;
        end
        else if (press_reg[belpd_pkg::B_RESET] && (hold_reg != '1))
        begin
            hold_next = hold_reg + belpd_pkg::HOLD_BITS'(1);
        end

        long_upd = long_reg;
        if (rises[belpd_pkg::B_RESET])
        begin
            long_upd = (belpd_pkg::CMP_W'(hold_next) >= belpd_pkg::CMP_W'(limit_reg));
        end

        pend_upd   = pend_reg | rises;
        press_next = (press_reg & ~rises) | falls;
        last_next  = lv;
        pend_next  = pend_upd;
        long_next  = long_upd;

        result.button_id  = belpd_pkg::BTN_NONE;
        result.event_kind = belpd_pkg::KIND_SHORT;
        live_bit          = 1'b1;

        case (item.op)
            belpd_pkg::OP_POLL:
            begin
                if (pend_upd[belpd_pkg::B_POWER])
                begin
                    result.button_id = belpd_pkg::BTN_POWER;
                    pend_next[belpd_pkg::B_POWER] = 1'b0;
                end
                else if (pend_upd[belpd_pkg::B_SELECT])
                begin
                    result.button_id = belpd_pkg::BTN_SELECT;
                    pend_next[belpd_pkg::B_SELECT] = 1'b0;
                end
                else if (pend_upd[belpd_pkg::B_RESET])
                begin
                    result.button_id  = belpd_pkg::BTN_RESET;
                    result.event_kind = long_upd ? belpd_pkg::KIND_LONG
                                                 : belpd_pkg::KIND_SHORT;
                    pend_next[belpd_pkg::B_RESET] = 1'b0;
                    long_next = 1'b0;
                end
            end
            belpd_pkg::OP_STATUS:
            begin
                case (belpd_pkg::sel_t'(item.status_button))
                    belpd_pkg::SEL_POWER:
                    begin
                        result.button_id = belpd_pkg::BTN_POWER;
                        live_bit = lv[belpd_pkg::B_POWER];
                    end
                    belpd_pkg::SEL_RESET:
                    begin
                        result.button_id = belpd_pkg::BTN_RESET;
                        live_bit = lv[belpd_pkg::B_RESET];
                    end
                    belpd_pkg::SEL_SELECT:
                    begin
                        result.button_id = belpd_pkg::BTN_SELECT;
                        live_bit = lv[belpd_pkg::B_SELECT];
                    end
                    default:
                    begin
                        result.button_id = belpd_pkg::BTN_NONE;
                        live_bit = 1'b1;
                    end
                endcase
                result.event_kind = live_bit ? belpd_pkg::KIND_RELEASED
                                             : belpd_pkg::KIND_PRESSED;
            end
            default:
            begin
                result.button_id  = belpd_pkg::BTN_NONE;
                result.event_kind = belpd_pkg::KIND_SHORT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg  <= 3'b111;
            press_reg <= '0;
            pend_reg  <= '0;
            hold_reg  <= '0;
            long_reg  <= 1'b0;
        end
        else if (fire)
        begin
            last_reg  <= last_next;
            press_reg <= press_next;
            pend_reg  <= pend_next;
            hold_reg  <= hold_next;
            long_reg  <= long_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/belpd_out_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// belpd_out_stage: result register
// Holds one result item on the master stream until it is taken.
// ----------------------------------------------------------------------------
module belpd_out_stage
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire belpd_pkg::result_t   result,
    output logic                      free,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [7:0]                m_tdata
);

    logic               valid_reg;
    logic               valid_next;
    belpd_pkg::result_t result_reg;

    assign free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'b0000, result_reg.event_kind, result_reg.button_id};

endmodule
`default_nettype wire

@@ rtl/button_event_long_press_detector.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// button_event_long_press_detector: button event and long-press detector
// Tracks presses and releases of three active-low buttons per time tick,
// latches pending events, times the reset button and answers host requests.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle unless the item's result would
// overwrite a stalled one; an accepted item is held in the input register,
// and the state update and request decode sit between it and the result
// register, which presents the result on the master side.
// Tick-only items (request code 0, and the unused code 3) update the state
// and produce no result; poll and status requests produce exactly one. The
// input keeps flowing while a finished result waits on the master side;
// only a result that would overwrite a stalled one holds the input back.
// The long-press threshold (long_seconds+1)*ticks_per_second is computed
// once on each register write and kept in a register, so the per-item path
// is only a hold counter increment and one compare. Write configuration
// only while the block is idle.
// ----------------------------------------------------------------------------
module button_event_long_press_detector
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    // Configuration: index 0 ticks_per_second, index 1 long_seconds
    input  wire logic                              cfg_we,
    input  wire logic [belpd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [belpd_pkg::CFG_W-1:0]       cfg_wdata,

    // Tick items in
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [0] power_level, [1] select_level, [2] reset_level,
    // [4:3] status_button, [7:5] zero
    input  wire logic [7:0]                        s_tdata,
    // [1:0] op
    input  wire logic [1:0]                        s_tuser,

    // Result items out
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [1:0] button_id, [3:2] event_kind, [7:4] zero
    output logic [7:0]                             m_tdata
);

    belpd_pkg::item_t   item;
    logic               item_valid;
    belpd_pkg::result_t result;
    logic               out_free;
    logic               needs_out;
    logic               advance;

    // Advance the held item when its result, if any, has room downstream
    assign needs_out = belpd_pkg::op_has_result(item.op);
    assign advance   = item_valid && (!needs_out || out_free);

    belpd_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item       (item),
        .item_valid (item_valid)
    );

    // State is committed only on advance, so a stalled item is replayed
    // against unchanged state
    belpd_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .item      (item),
        .fire      (advance),
        .result    (result)
    );

    belpd_out_stage u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && needs_out),
        .result   (result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire

@@ rtl/belpd_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// belpd_checker: port-level checks of the long-press detector
// Result encoding and output stream behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
module belpd_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    // Only the reset button can report a long event
    a_long_reset_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[3:2] == belpd_pkg::KIND_LONG)
        |-> (m_tdata[1:0] == belpd_pkg::BTN_RESET))
        else $error("long event on a button other than reset");

    // A pressed-now status always names a real button
    a_pressed_has_button: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[3:2] == belpd_pkg::KIND_PRESSED)
        |-> (m_tdata[1:0] != belpd_pkg::BTN_NONE))
        else $error("pressed status without a button");

    // No result in the cycle after reset is seen
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result valid during reset");

endmodule

bind button_event_long_press_detector belpd_checker u_belpd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
